// File: hdl/ctlc_pkg.sv
// shared widths, payload types and constants for the cubic trajectory limit check
// no dependencies; imported by every module of the block
package ctlc_pkg;

   localparam int POS_W       = 32;
   localparam int TIME_W      = 31;
   localparam int FRAC_BITS   = 16;
   localparam int COEF_W      = 52;
   localparam int EVAL_W      = 56;
   localparam int NORM_W      = 32;
   localparam int NORM_MSB    = 29;
   localparam int DISC_W      = 64;
   localparam int ROOT_W      = 32;
   localparam int NUM_W       = 34;
   localparam int S_W         = 17;
   localparam int SQRT_LAT    = 32;
   localparam int DIV_STEPS   = 16;
   localparam int DIV_LAT     = DIV_STEPS + 1;
   localparam int HORNER_LAT  = 3;
   localparam int PRE_LAT     = 5;
   localparam int EXT_LAT     = PRE_LAT + SQRT_LAT + DIV_LAT + HORNER_LAT + 1;

   localparam logic [TIME_W-1:0] RETURN_TIME_RESET = TIME_W'(65536);
   localparam logic [S_W-1:0]    ONE_Q             = S_W'(65536);

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [EVAL_W-1:0] eval_type;
   typedef logic signed [NUM_W-1:0]  num_type;

endpackage

// File: hdl/ctlc_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on ctlc_pkg
module ctlc_isqrt (
   input  logic                        clock,
   input  logic [ctlc_pkg::DISC_W-2:0] radicand,
   output logic [ctlc_pkg::ROOT_W-1:0] root
);
   import ctlc_pkg::*;

   logic [DISC_W-1:0] x_ff [SQRT_LAT];
   logic [DISC_W-1:0] r_ff [SQRT_LAT];
   logic [DISC_W-1:0] x_in [SQRT_LAT];
   logic [DISC_W-1:0] r_in [SQRT_LAT];

   always_comb begin
      logic [DISC_W-1:0] xs;
      logic [DISC_W-1:0] rs;
      logic [DISC_W-1:0] bitv;
      logic [DISC_W-1:0] trial;
      for (int i = 0; i < SQRT_LAT; i++) begin
         xs    = (i == 0) ? {1'b0, radicand} : x_ff[(i == 0) ? 0 : i - 1];
         rs    = (i == 0) ? '0 : r_ff[(i == 0) ? 0 : i - 1];
         bitv  = DISC_W'(1) << (2 * (SQRT_LAT - 1 - i));
         trial = rs + bitv;
         if (xs >= trial) begin
            x_in[i] = xs - trial;
            r_in[i] = (rs >> 1) + bitv;
         end else begin
            x_in[i] = xs;
            r_in[i] = rs >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      r_ff <= r_in;
   end

   assign root = r_ff[SQRT_LAT-1][ROOT_W-1:0];

endmodule

// File: hdl/ctlc_div.sv
// pipelined root time divider: num/den clamped to [0,1] as unsigned Q1.16
// depends on ctlc_pkg
module ctlc_div (
   input  logic                     clock,
   input  ctlc_pkg::num_type        num,
   input  ctlc_pkg::num_type        den,
   input  logic                     force_zero,
   output logic [ctlc_pkg::S_W-1:0] s_out
);
   import ctlc_pkg::*;

   localparam int DIV_W = 32;

   typedef enum logic [1:0] {RC_ZERO, RC_ONE, RC_DIV} root_class_type;

   logic [DIV_W-1:0]     rem_ff [DIV_STEPS+1];
   logic [DIV_W-1:0]     den_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS+1];
   root_class_type       cls_ff [DIV_STEPS+1];

   num_type        n_abs;
   num_type        d_abs;
   root_class_type cls_in;

   always_comb begin
      n_abs = den[NUM_W-1] ? -num : num;
      d_abs = den[NUM_W-1] ? -den : den;
      if (force_zero || n_abs <= 0) begin
         cls_in = RC_ZERO;
      end else if (n_abs >= d_abs) begin
         cls_in = RC_ONE;
      end else begin
         cls_in = RC_DIV;
      end
   end

   always_ff @(posedge clock) begin
      logic [DIV_W:0] t;
      rem_ff[0] <= n_abs[DIV_W-1:0];
      den_ff[0] <= d_abs[DIV_W-1:0];
      q_ff[0]   <= '0;
      cls_ff[0] <= cls_in;
      for (int j = 1; j <= DIV_STEPS; j++) begin
         t = {rem_ff[j-1], 1'b0};
         if (t >= {1'b0, den_ff[j-1]}) begin
            rem_ff[j] <= DIV_W'(t - {1'b0, den_ff[j-1]});
            q_ff[j]   <= {q_ff[j-1][DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_ff[j] <= t[DIV_W-1:0];
            q_ff[j]   <= {q_ff[j-1][DIV_STEPS-2:0], 1'b0};
         end
         den_ff[j] <= den_ff[j-1];
         cls_ff[j] <= cls_ff[j-1];
      end
   end

   always_comb begin
      case (cls_ff[DIV_STEPS])
         RC_ONE:  s_out = ONE_Q;
         RC_DIV:  s_out = {{(S_W-DIV_STEPS){1'b0}}, q_ff[DIV_STEPS]};
         default: s_out = '0;
      endcase
   end

endmodule

// File: hdl/ctlc_horner.sv
// three stage horner evaluation of a cubic at a Q1.16 time
// depends on ctlc_pkg
module ctlc_horner (
   input  logic                     clock,
   input  ctlc_pkg::coef_type       a,
   input  ctlc_pkg::coef_type       b,
   input  ctlc_pkg::coef_type       c,
   input  ctlc_pkg::pos_type        d,
   input  logic [ctlc_pkg::S_W-1:0] s,
   output ctlc_pkg::eval_type       p
);
   import ctlc_pkg::*;

   // floor(h * s / 2^16)
   function automatic eval_type mul_frac(eval_type h, logic [S_W-1:0] sv);
      logic signed [EVAL_W+S_W:0] prod;
      prod = h * $signed({1'b0, sv});
      return prod[EVAL_W+FRAC_BITS-1:FRAC_BITS];
   endfunction

   eval_type       h1_ff, h2_ff, p_ff;
   coef_type       c1_ff;
   pos_type        d1_ff, d2_ff;
   logic [S_W-1:0] s1_ff, s2_ff;

   always_ff @(posedge clock) begin
      h1_ff <= mul_frac(EVAL_W'(a), s) + EVAL_W'(b);
      c1_ff <= c;
      d1_ff <= d;
      s1_ff <= s;
      h2_ff <= mul_frac(h1_ff, s1_ff) + EVAL_W'(c1_ff);
      d2_ff <= d1_ff;
      s2_ff <= s1_ff;
      p_ff  <= mul_frac(h2_ff, s2_ff) + EVAL_W'(d2_ff);
   end

   assign p = p_ff;

endmodule

// File: hdl/ctlc_extrema.sv
// extrema of one cubic segment: normalize, discriminant, sqrt, root times, evaluate
// depends on ctlc_pkg, ctlc_isqrt, ctlc_div, ctlc_horner
module ctlc_extrema (
   input  logic               clock,
   input  ctlc_pkg::coef_type a,
   input  ctlc_pkg::coef_type b,
   input  ctlc_pkg::coef_type c,
   input  ctlc_pkg::pos_type  d,
   output ctlc_pkg::eval_type hi_val,
   output ctlc_pkg::eval_type lo_val
);
   import ctlc_pkg::*;

   localparam int MSB_W = $clog2(COEF_W);

   typedef struct packed {
      logic signed [NORM_W-1:0] na;
      logic signed [NORM_W-1:0] nb;
      logic                     noroot;
      coef_type                 a;
      coef_type                 b;
      coef_type                 c;
      pos_type                  d;
   } side_type;

   typedef struct packed {
      coef_type a;
      coef_type b;
      coef_type c;
      pos_type  d;
   } coef_side_type;

   function automatic logic [MSB_W-1:0] msb_index(logic [COEF_W-1:0] m);
      logic [MSB_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < COEF_W; i++) begin
         if (m[i]) idx = MSB_W'(i);
      end
      return idx;
   endfunction

   function automatic coef_type magnitude(coef_type x);
      return x[COEF_W-1] ? -x : x;
   endfunction

   function automatic logic signed [NORM_W-1:0] norm_shift(coef_type x, logic [MSB_W-1:0] p);
      coef_type y;
      if (p >= MSB_W'(NORM_MSB)) begin
         y = x >>> (p - MSB_W'(NORM_MSB));
      end else begin
         y = x <<< (MSB_W'(NORM_MSB) - p);
      end
      return y[NORM_W-1:0];
   endfunction

   // stage 1: largest magnitude
   coef_type         ma, mb, mc, mab;
   logic [COEF_W-1:0] m1_ff;
   coef_side_type    cs1_ff, cs2_ff, cs3_ff, cs4_ff, cs5_ff;
   // stage 2: leading one
   logic [MSB_W-1:0] p2_ff;
   // stage 3: normalized coefficients
   logic signed [NORM_W-1:0] na3_ff, nb3_ff, nc3_ff;
   // stage 4: products
   logic signed [DISC_W-1:0] nbb4_ff, nac4_ff;
   logic signed [NORM_W-1:0] na4_ff, nb4_ff, na5_ff, nb5_ff;
   logic                     zero4_ff, zero5_ff;
   // stage 5: discriminant
   logic signed [DISC_W-1:0] disc5_ff;

   always_comb begin
      ma  = magnitude(a);
      mb  = magnitude(b);
      mc  = magnitude(c);
      mab = (mb > ma) ? mb : ma;
   end

   always_ff @(posedge clock) begin
      m1_ff    <= (mc > mab) ? mc : mab;
      cs1_ff   <= '{a: a, b: b, c: c, d: d};
      p2_ff    <= msb_index(m1_ff);
      cs2_ff   <= cs1_ff;
      // zero magnitude leaves all three at zero, which flags no root below
      na3_ff   <= norm_shift(cs2_ff.a, p2_ff);
      nb3_ff   <= norm_shift(cs2_ff.b, p2_ff);
      nc3_ff   <= norm_shift(cs2_ff.c, p2_ff);
      cs3_ff   <= cs2_ff;
      nbb4_ff  <= DISC_W'(nb3_ff * nb3_ff);
      nac4_ff  <= DISC_W'(na3_ff * nc3_ff);
      na4_ff   <= na3_ff;
      nb4_ff   <= nb3_ff;
      zero4_ff <= (na3_ff == '0);
      cs4_ff   <= cs3_ff;
      disc5_ff <= nbb4_ff - (nac4_ff + (nac4_ff <<< 1));
      na5_ff   <= na4_ff;
      nb5_ff   <= nb4_ff;
      zero5_ff <= zero4_ff;
      cs5_ff   <= cs4_ff;
   end

   // square root with side data alongside
   logic [DISC_W-2:0] radicand;
   logic [ROOT_W-1:0] root;
   side_type          side_in;
   side_type          side_ff [SQRT_LAT];

   assign radicand = disc5_ff[DISC_W-1] ? '0 : disc5_ff[DISC_W-2:0];

   always_comb begin
      side_in.na     = na5_ff;
      side_in.nb     = nb5_ff;
      side_in.noroot = zero5_ff || disc5_ff[DISC_W-1];
      side_in.a      = cs5_ff.a;
      side_in.b      = cs5_ff.b;
      side_in.c      = cs5_ff.c;
      side_in.d      = cs5_ff.d;
   end

   ctlc_isqrt u_isqrt (
      .clock    (clock),
      .radicand (radicand),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < SQRT_LAT; i++) side_ff[i] <= side_ff[i-1];
   end

   // root times
   side_type        sd;
   num_type         r_ext, nb_ext, na_ext;
   num_type         num_plus, num_minus, den3;
   logic [S_W-1:0]  s_plus, s_minus;
   coef_side_type   cside_ff [DIV_LAT];

   always_comb begin
      sd        = side_ff[SQRT_LAT-1];
      r_ext     = $signed({{(NUM_W-ROOT_W){1'b0}}, root});
      nb_ext    = NUM_W'(sd.nb);
      na_ext    = NUM_W'(sd.na);
      num_plus  = r_ext - nb_ext;
      num_minus = -nb_ext - r_ext;
      den3      = na_ext + (na_ext <<< 1);
   end

   ctlc_div u_div_plus (
      .clock      (clock),
      .num        (num_plus),
      .den        (den3),
      .force_zero (sd.noroot),
      .s_out      (s_plus)
   );

   ctlc_div u_div_minus (
      .clock      (clock),
      .num        (num_minus),
      .den        (den3),
      .force_zero (sd.noroot),
      .s_out      (s_minus)
   );

   always_ff @(posedge clock) begin
      cside_ff[0] <= '{a: sd.a, b: sd.b, c: sd.c, d: sd.d};
      for (int i = 1; i < DIV_LAT; i++) cside_ff[i] <= cside_ff[i-1];
   end

   // evaluate both candidates
   eval_type p_plus, p_minus;
   eval_type hi_ff, lo_ff;

   ctlc_horner u_horner_plus (
      .clock (clock),
      .a     (cside_ff[DIV_LAT-1].a),
      .b     (cside_ff[DIV_LAT-1].b),
      .c     (cside_ff[DIV_LAT-1].c),
      .d     (cside_ff[DIV_LAT-1].d),
      .s     (s_plus),
      .p     (p_plus)
   );

   ctlc_horner u_horner_minus (
      .clock (clock),
      .a     (cside_ff[DIV_LAT-1].a),
      .b     (cside_ff[DIV_LAT-1].b),
      .c     (cside_ff[DIV_LAT-1].c),
      .d     (cside_ff[DIV_LAT-1].d),
      .s     (s_minus),
      .p     (p_minus)
   );

   always_ff @(posedge clock) begin
      hi_ff <= (p_plus > p_minus) ? p_plus : p_minus;
      lo_ff <= (p_plus < p_minus) ? p_plus : p_minus;
   end

   assign hi_val = hi_ff;
   assign lo_val = lo_ff;

endmodule

// File: hdl/cubic_trajectory_limit_check.sv
// top level of the cubic trajectory limit check
// depends on ctlc_pkg and ctlc_extrema
//
// A request is taken at every rising edge with start high; busy stays low, the
// pipeline takes one request per cycle with no gaps. Each request carries one
// joint: start, hit and rest positions, start and hit velocities, hit time and
// the two limits. The return duration comes from the single csr register
// (csr_write / csr_wdata), one second after reset, sampled when a request is
// taken.
// Every request gives one result, shown for one cycle with rsp_valid high;
// results leave in request order, one per cycle at most.
// The latency is set by the 32 stage square root, the 17 stage root time
// divider and the three stage horner evaluation, behind three stages of
// coefficient setup and five of normalization and discriminant.
// The receiver cannot stall, so nothing is held back at the output.
// Synchronous reset clears the valid bits of every stage and reloads the
// return duration; requests in flight at reset are dropped.
module cubic_trajectory_limit_check (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ctlc_pkg::pos_type           req_start_pos,
   input  ctlc_pkg::pos_type           req_start_vel,
   input  ctlc_pkg::pos_type           req_hit_pos,
   input  ctlc_pkg::pos_type           req_hit_vel,
   input  logic [ctlc_pkg::TIME_W-1:0] req_hit_time,
   input  ctlc_pkg::pos_type           req_rest_pos,
   input  ctlc_pkg::pos_type           req_upper_limit,
   input  ctlc_pkg::pos_type           req_lower_limit,
   input  logic                        csr_write,
   input  logic [ctlc_pkg::TIME_W-1:0] csr_wdata,
   output logic                        rsp_valid,
   output ctlc_pkg::pos_type           rsp_strike_over,
   output ctlc_pkg::pos_type           rsp_strike_under,
   output ctlc_pkg::pos_type           rsp_return_over,
   output ctlc_pkg::pos_type           rsp_return_under
);
   import ctlc_pkg::*;

   localparam int PROD_W = 2 * POS_W;
   localparam int TV_W   = PROD_W - FRAC_BITS;

   typedef struct packed {
      pos_type ub;
      pos_type lb;
   } limit_type;

   function automatic pos_type sat32(logic signed [EVAL_W:0] x);
      if (x > $signed((EVAL_W+1)'({1'b0, {(POS_W-1){1'b1}}}))) begin
         return {1'b0, {(POS_W-1){1'b1}}};
      end else if (x < -$signed((EVAL_W+1)'({1'b1, {(POS_W-1){1'b0}}}))) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end
      return x[POS_W-1:0];
   endfunction

   logic accept;
   logic [TIME_W-1:0] return_time_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         return_time_ff <= RETURN_TIME_RESET;
      end else if (csr_write) begin
         return_time_ff <= csr_wdata;
      end
   end

   // request stage
   logic              valid_r_ff, valid_p_ff, valid_c_ff;
   pos_type           q0_r_ff, v0_r_ff, qf_r_ff, vf_r_ff, qr_r_ff;
   logic [TIME_W-1:0] th_r_ff, tr_r_ff;
   limit_type         lim_r_ff, lim_p_ff, lim_c_ff;

   // product stage
   logic signed [TV_W-1:0] tv0_p_ff, tvf_p_ff, rvf_p_ff;
   pos_type                q0_p_ff, qf_p_ff, qr_p_ff;

   // coefficient stage
   coef_type sa_ff, sb_ff, sc_ff, ra_ff, rb_ff, rc_ff;
   pos_type  sd_ff, rd_ff;

   logic signed [PROD_W-1:0] prod_tv0, prod_tvf, prod_rvf;
   coef_type qd, rdf, tv0x, tvfx, rvfx;

   always_comb begin
      prod_tv0 = $signed({1'b0, th_r_ff}) * v0_r_ff;
      prod_tvf = $signed({1'b0, th_r_ff}) * vf_r_ff;
      prod_rvf = $signed({1'b0, tr_r_ff}) * vf_r_ff;
      qd       = COEF_W'(qf_p_ff) - COEF_W'(q0_p_ff);
      rdf      = COEF_W'(qr_p_ff) - COEF_W'(qf_p_ff);
      tv0x     = COEF_W'(tv0_p_ff);
      tvfx     = COEF_W'(tvf_p_ff);
      rvfx     = COEF_W'(rvf_p_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_r_ff <= 1'b0;
         valid_p_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_r_ff <= accept;
         valid_p_ff <= valid_r_ff;
         valid_c_ff <= valid_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      q0_r_ff  <= req_start_pos;
      v0_r_ff  <= req_start_vel;
      qf_r_ff  <= req_hit_pos;
      vf_r_ff  <= req_hit_vel;
      th_r_ff  <= req_hit_time;
      qr_r_ff  <= req_rest_pos;
      tr_r_ff  <= return_time_ff;
      lim_r_ff <= '{ub: req_upper_limit, lb: req_lower_limit};
      // products floored to q32.16
      tv0_p_ff <= prod_tv0[PROD_W-1:FRAC_BITS];
      tvf_p_ff <= prod_tvf[PROD_W-1:FRAC_BITS];
      rvf_p_ff <= prod_rvf[PROD_W-1:FRAC_BITS];
      q0_p_ff  <= q0_r_ff;
      qf_p_ff  <= qf_r_ff;
      qr_p_ff  <= qr_r_ff;
      lim_p_ff <= lim_r_ff;
      sa_ff    <= tv0x + tvfx - (qd <<< 1);
      sb_ff    <= qd + (qd <<< 1) - tvfx - (tv0x <<< 1);
      sc_ff    <= tv0x;
      sd_ff    <= q0_p_ff;
      ra_ff    <= rvfx - (rdf <<< 1);
      rb_ff    <= rdf + (rdf <<< 1) - (rvfx <<< 1);
      rc_ff    <= rvfx;
      rd_ff    <= qf_p_ff;
      lim_c_ff <= lim_p_ff;
   end

   eval_type smax, smin, rmax, rmin;

   ctlc_extrema u_strike (
      .clock  (clock),
      .a      (sa_ff),
      .b      (sb_ff),
      .c      (sc_ff),
      .d      (sd_ff),
      .hi_val (smax),
      .lo_val (smin)
   );

   ctlc_extrema u_return (
      .clock  (clock),
      .a      (ra_ff),
      .b      (rb_ff),
      .c      (rc_ff),
      .d      (rd_ff),
      .hi_val (rmax),
      .lo_val (rmin)
   );

   // limits and valid bits ride alongside the extrema pipeline
   logic [EXT_LAT-1:0] valid_ext_ff;
   limit_type          lim_ext_ff [EXT_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ext_ff <= '0;
      end else begin
         valid_ext_ff <= {valid_ext_ff[EXT_LAT-2:0], valid_c_ff};
      end
   end

   always_ff @(posedge clock) begin
      lim_ext_ff[0] <= lim_c_ff;
      for (int i = 1; i < EXT_LAT; i++) lim_ext_ff[i] <= lim_ext_ff[i-1];
   end

   limit_type lim_o;
   logic signed [EVAL_W:0] s_over, s_under, r_over, r_under;

   always_comb begin
      lim_o   = lim_ext_ff[EXT_LAT-1];
      s_over  = (EVAL_W+1)'(smax) - (EVAL_W+1)'(lim_o.ub);
      s_under = (EVAL_W+1)'(lim_o.lb) - (EVAL_W+1)'(smin);
      r_over  = (EVAL_W+1)'(rmax) - (EVAL_W+1)'(lim_o.ub);
      r_under = (EVAL_W+1)'(lim_o.lb) - (EVAL_W+1)'(rmin);
   end

   logic    rsp_valid_ff;
   pos_type s_over_ff, s_under_ff, r_over_ff, r_under_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ext_ff[EXT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      s_over_ff  <= sat32(s_over);
      s_under_ff <= sat32(s_under);
      r_over_ff  <= sat32(r_over);
      r_under_ff <= sat32(r_under);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_strike_over  = s_over_ff;
   assign rsp_strike_under = s_under_ff;
   assign rsp_return_over  = r_over_ff;
   assign rsp_return_under = r_under_ff;

endmodule

// File: tb/testbench.sv
// self-checking testbench for cubic_trajectory_limit_check
// depends on ctlc_pkg and the block's rtl; predicts untyped results with its own integer model
module testbench;
   import ctlc_pkg::*;

   typedef struct {
      pos_type             start_pos, start_vel, hit_pos, hit_vel;
      logic [TIME_W-1:0]   hit_time;
      pos_type             rest_pos, upper_limit, lower_limit;
      bit                  typed;
      pos_type             e_so, e_su, e_ro, e_ru;
   } joint_req_type;

   typedef struct {
      pos_type so, su, ro, ru;
   } violation_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pos_type req_start_pos = '0, req_start_vel = '0, req_hit_pos = '0, req_hit_vel = '0;
   logic [TIME_W-1:0] req_hit_time = '0;
   pos_type req_rest_pos = '0, req_upper_limit = '0, req_lower_limit = '0;
   logic csr_write = 1'b0;
   logic [TIME_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   pos_type rsp_strike_over, rsp_strike_under, rsp_return_over, rsp_return_under;

   violation_type pending_violations[$];
   longint        return_time_model = 65536;
   bit            failed = 1'b0;
   int            idle_cycles = 0;

   always #2 clock = ~clock;

   cubic_trajectory_limit_check i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_pos(req_start_pos), .req_start_vel(req_start_vel),
      .req_hit_pos(req_hit_pos), .req_hit_vel(req_hit_vel),
      .req_hit_time(req_hit_time), .req_rest_pos(req_rest_pos),
      .req_upper_limit(req_upper_limit), .req_lower_limit(req_lower_limit),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_strike_over(rsp_strike_over), .rsp_strike_under(rsp_strike_under),
      .rsp_return_over(rsp_return_over), .rsp_return_under(rsp_return_under)
   );

   // ---------------- predictor ----------------
   function automatic longint frac_scale(longint h, longint s);
      longint hi, lo;
      if (s >= 65536) return h;
      hi = h >>> 16;
      lo = h - (hi <<< 16);
      return hi * s + ((lo * s) >>> 16);
   endfunction

   function automatic longint int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint clamp_time(longint num, longint den);
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num <= 0) return 0;
      if (num >= den) return 65536;
      return (num * 65536) / den;
   endfunction

   function automatic longint horner(longint a, longint b, longint c, longint d, longint s);
      longint h;
      h = frac_scale(a, s) + b;
      h = frac_scale(h, s) + c;
      return frac_scale(h, s) + d;
   endfunction

   function automatic longint abs64(longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic void cubic_extrema(input longint a, b, c, d,
                                         output longint hi_v, lo_v);
      longint s1, s2, v1, v2, na, nb, nc, m, disc, r;
      int k;
      s1 = 0; s2 = 0;
      na = a; nb = b; nc = c;
      m = abs64(a);
      if (abs64(b) > m) m = abs64(b);
      if (abs64(c) > m) m = abs64(c);
      if (m != 0) begin
         k = 0;
         if (m >= (64'sd1 << 30)) begin
            while ((m >> k) >= (64'sd1 << 30)) k++;
            na = a >>> k; nb = b >>> k; nc = c >>> k;
         end else begin
            while ((m << k) < (64'sd1 << 29)) k++;
            na = a <<< k; nb = b <<< k; nc = c <<< k;
         end
         if (na != 0) begin
            disc = nb * nb - 3 * na * nc;
            if (disc >= 0) begin
               r  = int_sqrt(disc);
               s1 = clamp_time(-nb + r, 3 * na);
               s2 = clamp_time(-nb - r, 3 * na);
            end
         end
      end
      v1 = horner(a, b, c, d, s1);
      v2 = horner(a, b, c, d, s2);
      hi_v = v1 > v2 ? v1 : v2;
      lo_v = v1 < v2 ? v1 : v2;
   endfunction

   function automatic pos_type saturate(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return pos_type'(x);
   endfunction

   function automatic violation_type predict_violations(joint_req_type q);
      violation_type o;
      longint q0, v0, qf, vf, th, qr, tv0, tvf, rvf, smax, smin, rmax, rmin;
      q0 = q.start_pos; v0 = q.start_vel; qf = q.hit_pos; vf = q.hit_vel;
      th = longint'(q.hit_time); qr = q.rest_pos;
      tv0 = (th * v0) >>> 16;
      tvf = (th * vf) >>> 16;
      cubic_extrema(2 * (q0 - qf) + tv0 + tvf, 3 * (qf - q0) - tvf - 2 * tv0, tv0, q0,
                    smax, smin);
      rvf = (return_time_model * vf) >>> 16;
      cubic_extrema(2 * (qf - qr) + rvf, 3 * (qr - qf) - 2 * rvf, rvf, qf, rmax, rmin);
      o.so = saturate(smax - longint'(q.upper_limit));
      o.su = saturate(longint'(q.lower_limit) - smin);
      o.ro = saturate(rmax - longint'(q.upper_limit));
      o.ru = saturate(longint'(q.lower_limit) - rmin);
      return o;
   endfunction

   // ---------------- response checking ----------------
   task automatic compare_field(string name, pos_type e, pos_type a);
      if (e !== a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         failed = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      violation_type e;
      if (!reset && rsp_valid) begin
         if (pending_violations.size() == 0) begin
            $error("result with no request outstanding");
            failed = 1'b1;
         end else begin
            e = pending_violations.pop_front();
            compare_field("strike_over",  e.so, rsp_strike_over);
            compare_field("strike_under", e.su, rsp_strike_under);
            compare_field("return_over",  e.ro, rsp_return_over);
            compare_field("return_under", e.ru, rsp_return_under);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- stimulus ----------------
   function automatic joint_req_type joint(longint p0, v0, pf, vf, th, pr, ub, lb);
      joint_req_type q;
      q.start_pos = pos_type'(p0); q.start_vel = pos_type'(v0);
      q.hit_pos = pos_type'(pf); q.hit_vel = pos_type'(vf);
      q.hit_time = TIME_W'(th); q.rest_pos = pos_type'(pr);
      q.upper_limit = pos_type'(ub); q.lower_limit = pos_type'(lb);
      q.typed = 1'b0;
      return q;
   endfunction

   function automatic joint_req_type with_expect(joint_req_type q, longint so, su, ro, ru);
      q.typed = 1'b1;
      q.e_so = pos_type'(so); q.e_su = pos_type'(su);
      q.e_ro = pos_type'(ro); q.e_ru = pos_type'(ru);
      return q;
   endfunction

   function automatic pos_type near_pos();
      return pos_type'(longint'($urandom_range(0, 1 << 19)) - (1 << 18));
   endfunction

   function automatic joint_req_type random_joint();
      joint_req_type q;
      if ($urandom_range(0, 9) == 0) begin
         // full range noise
         q = joint(0, 0, 0, 0, 0, 0, 0, 0);
         q.start_pos = $urandom; q.start_vel = $urandom; q.hit_pos = $urandom;
         q.hit_vel = $urandom; q.hit_time = TIME_W'($urandom); q.rest_pos = $urandom;
         q.upper_limit = $urandom; q.lower_limit = $urandom;
      end else begin
         q = joint(near_pos(), near_pos() <<< 1, near_pos(), near_pos() <<< 1,
                   $urandom_range(6554, 131072), near_pos(), 0, 0);
         q.upper_limit = near_pos() + (1 << 18);
         q.lower_limit = near_pos() - (1 << 18);
      end
      return q;
   endfunction

   task automatic send_joint(joint_req_type q);
      int gap;
      req_start_pos <= q.start_pos;   req_start_vel <= q.start_vel;
      req_hit_pos <= q.hit_pos;       req_hit_vel <= q.hit_vel;
      req_hit_time <= q.hit_time;     req_rest_pos <= q.rest_pos;
      req_upper_limit <= q.upper_limit; req_lower_limit <= q.lower_limit;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (q.typed)
         pending_violations.push_back('{q.e_so, q.e_su, q.e_ro, q.e_ru});
      else
         pending_violations.push_back(predict_violations(q));
      case ($urandom_range(0, 19))
         0:             gap = $urandom_range(10, 40);
         1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
         default:       gap = 0;
      endcase
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_violations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_return_time(logic [TIME_W-1:0] v);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      return_time_model = longint'(v);
   endtask

   localparam longint PMAX = 64'sd2147483647;
   localparam longint PMIN = -64'sd2147483648;
   localparam longint TMAX = 64'sd2147483647;

   joint_req_type directed[$];
   logic [TIME_W-1:0] return_settings[5] = '{31'h7fffffff, 31'd1, 31'd0, 31'h18000, 31'h8000};

   initial begin
      directed.push_back(with_expect(joint(0, 0, 0, 0, 65536, 0, 0, 0), 0, 0, 0, 0));
      directed.push_back(with_expect(joint(0, 0, 0, 0, 65536, 0, PMIN, PMAX),
                                     PMAX, PMAX, PMAX, PMAX));
      directed.push_back(with_expect(joint(0, 0, 0, 0, 65536, 0, PMAX, PMIN),
                                     -PMAX, PMIN, -PMAX, PMIN));
      // motionless joint sits on both limits
      directed.push_back(with_expect(joint(12345, 0, 12345, 0, TMAX, 12345, 12345, 12345),
                                     0, 0, 0, 0));
      directed.push_back(joint(PMAX, PMAX, PMIN, PMIN, TMAX, PMAX, 0, 0));
      directed.push_back(joint(PMIN, PMIN, PMAX, PMAX, TMAX, PMIN, PMAX, PMIN));
      directed.push_back(joint(PMIN, PMAX, PMIN, PMAX, 1, PMAX, PMIN, PMAX));
      directed.push_back(joint(65536, 131072, -65536, 65536, 0, 0, 65536, -65536));
      directed.push_back(joint(0, 65536, 65536, 0, 65536, 0, 32768, -32768));
      directed.push_back(joint(0, -200000, 100000, 300000, 49152, -50000, 60000, -60000));
      // overshooting strike, real extremum inside the segment
      directed.push_back(joint(0, 400000, 0, -400000, 65536, 0, 10000, -10000));
      // linear motion, cubic coefficient cancels
      directed.push_back(joint(0, 65536, 65536, 65536, 65536, 65536, 0, 0));
      directed.push_back(joint(-300000, 0, 300000, 0, 65536, -300000, 250000, -250000));
      directed.push_back(joint(1, -1, -1, 1, 2, 1, -1, 1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_joint(directed[i]);
      for (int i = 0; i < 60; i++) send_joint(random_joint());
      drain();

      foreach (return_settings[p]) begin
         write_return_time(return_settings[p]);
         for (int i = 0; i < 110; i++) send_joint(random_joint());
         drain();
      end

      if (!failed) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/ctlc_pkg.sv
hdl/ctlc_isqrt.sv
hdl/ctlc_div.sv
hdl/ctlc_horner.sv
hdl/ctlc_extrema.sv
hdl/cubic_trajectory_limit_check.sv
tb/testbench.sv
